// ===== rtl/sha_pkg.sv =====
// sha_pkg: shared types, constants and round functions for the sha-256 engine
// no dependencies
`default_nettype none
package sha_pkg;

    localparam int LEN_BITS_DEFAULT = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } sha_out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } sha_cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[i];
    endfunction

    function automatic logic [31:0] init_value(input logic variant, input logic [2:0] i);
        logic [31:0] iv [16];
        iv = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
            32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
            32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
        };
        init_value = iv[{variant, i}];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_front.sv =====
// sha_front: accepts input transactions, clamps byte counts, marks message end
// depends on sha_pkg
`default_nettype none
module sha_front
    import sha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sha_in_t  in_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output sha_cmd_t      q_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    sha_cmd_t            mem [QUEUE_DEPTH];
    logic [PW-1:0]       wp_reg, rp_reg;
    logic [PW:0]         cnt_reg;
    sha_cmd_t            cls;
    logic                push, pop;

    always_comb
    begin
        cls.word   = in_data.data_word;
        cls.nbytes = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
        // short word ends the message
        cls.last   = in_data.last_word || (cls.nbytes != 3'd4);
    end

    assign in_ready = (cnt_reg != QUEUE_DEPTH[PW:0]);
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sha_back.sv =====
// sha_back: block buffer, padding, 64-round compression and digest output
// depends on sha_pkg
`default_nettype none
module sha_back
    import sha_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = LEN_BITS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_valid,
    input  wire logic     cfg_data,
    input  wire logic     q_valid,
    output logic          q_ready,
    input  wire sha_cmd_t q_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sha_out_t      out_data,
    output logic          busy
);
    localparam int LB = LENGTH_COUNTER_BITS;

    typedef enum logic [4:0] {
        ST_TAKE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t        state_reg;
    logic          variant_reg;
    logic [31:0]   w_reg [16];      // sliding schedule window, doubles as block buffer
    logic [3:0]    pos_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [LB-1:0] bcnt_reg;
    logic [5:0]    rnd_reg;
    logic          ending_reg;      // padding in progress
    logic [1:0]    padst_reg;       // 0: need 0x80 word, 1: zeros, 2: len hi, 3: len lo
    logic [2:0]    oidx_reg;

    logic [31:0]   pad_word;
    logic [63:0]   bits;
    logic [31:0]   keep, padb;
    logic          push;
    logic [31:0]   push_w;
    logic [31:0]   s0, s1, wnew, t1, t2;
    logic [2:0]    nlast;

    assign bits = 64'(bcnt_reg) << 3;

    always_comb
    begin
        case (q_data.nbytes)
            3'd0:    begin keep = 32'h00000000; padb = 32'h80000000; end
            3'd1:    begin keep = 32'hff000000; padb = 32'h00800000; end
            3'd2:    begin keep = 32'hffff0000; padb = 32'h00008000; end
            3'd3:    begin keep = 32'hffffff00; padb = 32'h00000080; end
            default: begin keep = 32'hffffffff; padb = 32'h00000000; end
        endcase
        case (padst_reg)
            2'd0:    pad_word = 32'h80000000;
            2'd1:    pad_word = 32'h0;
            2'd2:    pad_word = bits[63:32];
            default: pad_word = bits[31:0];
        endcase
    end

    assign q_ready = (state_reg == ST_TAKE);
    assign push = (state_reg == ST_TAKE && q_valid) || state_reg == ST_PAD;
    assign push_w = (state_reg == ST_PAD) ? pad_word
                  : (q_data.last ? ((q_data.word & keep) | padb) : q_data.word);

    // round datapath
    assign s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + s0 + w_reg[9] + s1;
    assign t1   = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
                + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
    assign t2   = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
                + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign nlast = variant_reg ? 3'd6 : 3'd7;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.digest_last = (oidx_reg == nlast);
    assign busy = (state_reg != ST_TAKE) || q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            w_reg[pos_reg] <= push_w;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int j = 0; j < 15; j++) w_reg[j] <= w_reg[j+1];
            w_reg[15] <= wnew;
        end
        if (push && pos_reg == 4'd15)
        begin
            for (int j = 0; j < 8; j++) v_reg[j] <= h_reg[j];
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_TAKE;
            variant_reg <= 1'b0;
            pos_reg     <= '0;
            bcnt_reg    <= '0;
            rnd_reg     <= '0;
            ending_reg  <= 1'b0;
            padst_reg   <= '0;
            oidx_reg    <= '0;
            for (int j = 0; j < 8; j++) h_reg[j] <= init_value(1'b0, 3'(j));
        end
        else if (cfg_valid)
        begin
            variant_reg <= cfg_data;
            pos_reg     <= '0;
            bcnt_reg    <= '0;
            rnd_reg     <= '0;
            ending_reg  <= 1'b0;
            state_reg   <= ST_TAKE;
            for (int j = 0; j < 8; j++) h_reg[j] <= init_value(cfg_data, 3'(j));
        end
        else
        begin
            unique case (state_reg)
                ST_TAKE, ST_PAD:
                begin
                    if (push)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (state_reg == ST_TAKE)
                        begin
                            bcnt_reg   <= bcnt_reg + LB'(q_data.nbytes);
                            ending_reg <= q_data.last;
                            padst_reg  <= (q_data.nbytes == 3'd4) ? 2'd0 : 2'd1;
                        end
                        else if (padst_reg == 2'd0 || padst_reg == 2'd2)
                        begin
                            padst_reg <= padst_reg + 2'd1;
                        end
                        else if (padst_reg == 2'd1 && pos_reg == 4'd13)
                        begin
                            padst_reg <= 2'd2;
                        end
                        if (pos_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (state_reg == ST_TAKE)
                        begin
                            if (q_data.last)
                            begin
                                // after the pad byte, length words go in slots 14 and 15
                                state_reg <= ST_PAD;
                                if (q_data.nbytes != 3'd4 && pos_reg == 4'd13)
                                begin
                                    padst_reg <= 2'd2;
                                end
                            end
                        end
                        else if (padst_reg == 2'd3)
                        begin
                            state_reg <= ST_TAKE;
                        end
                        else if (padst_reg == 2'd0 && pos_reg == 4'd13)
                        begin
                            padst_reg <= 2'd2;
                        end
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int j = 0; j < 8; j++) h_reg[j] <= h_reg[j] + v_reg[j];
                    if (!ending_reg)
                    begin
                        state_reg <= ST_TAKE;
                    end
                    else if (padst_reg == 2'd3 && pos_reg == 4'd0)
                    begin
                        state_reg <= ST_OUT;
                        oidx_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == nlast)
                        begin
                            state_reg  <= ST_TAKE;
                            ending_reg <= 1'b0;
                            bcnt_reg   <= '0;
                            for (int j = 0; j < 8; j++) h_reg[j] <= init_value(variant_reg, 3'(j));
                        end
                    end
                end
                default: state_reg <= ST_TAKE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sha256_hash_engine.sv =====
// sha256_hash_engine: streaming sha-256 / sha-224 engine, top level
// depends on sha_pkg, sha_front, sha_back
//
// in channel: one message word per transaction, with valid byte count and last mark
// out channel: the digest, 8 words (sha-256) or 7 words (sha-224), last marked
// cfg channel: one bit, 0 selects sha-256, 1 sha-224; a write aborts the message
// a front queue of four entries takes words while the back compresses
// the back takes one word a cycle into the block buffer while the queue has
// words; each full block then runs 64 rounds, one per cycle, and is then added
// into the chaining words
// the last word adds padding words at one per cycle and possibly a second block
// digest words leave one per cycle while out_ready is high; a stalled receiver
// holds the back, and the queue then fills and drops in_ready
// reset loads the sha-256 initial values and empties the queue
`default_nettype none
module sha256_hash_engine
    import sha_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = LEN_BITS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sha_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sha_out_t      out_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);
    logic     q_valid, q_ready, busy;
    sha_cmd_t q_data;

    assign cfg_ready = 1'b1;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sha_back #(.LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .busy(busy)
    );

`ifndef SYNTHESIS
    // digest never shown while the back takes words
    a_out_not_taking: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_ready) else $error("digest shown while taking words");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !cfg_valid) |=> out_valid) else $error("digest dropped");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy) else $error("busy low during output");
`endif
endmodule
`default_nettype wire
